// ----- hdl/taxe_pkg.sv -----
// Shared types, codes and expansion functions for the three-address expander.
`timescale 1ns / 1ps

package taxe_pkg;

  localparam int VALUE_W = 32;
  localparam int IDX_W   = 16;
  localparam int KIND_W  = 5;
  localparam int OP_W    = 5;
  localparam int OPK_W   = 3;
  localparam int COND_W  = 3;
  localparam int STEP_W  = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Three-address instruction kinds
  localparam logic [KIND_W-1:0] KIND_START  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_RETURN = 5'd1;
  localparam logic [KIND_W-1:0] KIND_NEG    = 5'd2;
  localparam logic [KIND_W-1:0] KIND_NOT    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_LNOT   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_ADD    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_SUB    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_MUL    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_AND    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_OR     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_XOR    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SHL    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_SHR    = 5'd12;
  localparam logic [KIND_W-1:0] KIND_DIV    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_REM    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_JMP    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_JZ     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_JNZ    = 5'd17;
  localparam logic [KIND_W-1:0] KIND_EQ     = 5'd18;
  localparam logic [KIND_W-1:0] KIND_NE     = 5'd19;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd20;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd21;
  localparam logic [KIND_W-1:0] KIND_GE     = 5'd22;
  localparam logic [KIND_W-1:0] KIND_LE     = 5'd23;
  localparam logic [KIND_W-1:0] KIND_COPY   = 5'd24;
  localparam logic [KIND_W-1:0] KIND_LABEL  = 5'd25;

  // x86-style opcodes
  localparam logic [OP_W-1:0] OP_MOV   = 5'd0;
  localparam logic [OP_W-1:0] OP_NEG   = 5'd1;
  localparam logic [OP_W-1:0] OP_NOT   = 5'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 5'd3;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd4;
  localparam logic [OP_W-1:0] OP_IMUL  = 5'd5;
  localparam logic [OP_W-1:0] OP_AND   = 5'd6;
  localparam logic [OP_W-1:0] OP_OR    = 5'd7;
  localparam logic [OP_W-1:0] OP_XOR   = 5'd8;
  localparam logic [OP_W-1:0] OP_SHL   = 5'd9;
  localparam logic [OP_W-1:0] OP_SAR   = 5'd10;
  localparam logic [OP_W-1:0] OP_CDQ   = 5'd11;
  localparam logic [OP_W-1:0] OP_IDIV  = 5'd12;
  localparam logic [OP_W-1:0] OP_CMP   = 5'd13;
  localparam logic [OP_W-1:0] OP_SETCC = 5'd14;
  localparam logic [OP_W-1:0] OP_JMP   = 5'd15;
  localparam logic [OP_W-1:0] OP_LABEL = 5'd16;
  localparam logic [OP_W-1:0] OP_RET   = 5'd17;

  // operand kinds
  localparam logic [OPK_W-1:0] OPK_IMM    = 3'd0;
  localparam logic [OPK_W-1:0] OPK_PSEUDO = 3'd1;
  localparam logic [OPK_W-1:0] OPK_AX     = 3'd2;
  localparam logic [OPK_W-1:0] OPK_CX     = 3'd3;
  localparam logic [OPK_W-1:0] OPK_DX     = 3'd4;
  localparam logic [OPK_W-1:0] OPK_R10    = 3'd5;
  localparam logic [OPK_W-1:0] OPK_R11    = 3'd6;

  // condition codes
  localparam logic [COND_W-1:0] COND_E  = 3'd0;
  localparam logic [COND_W-1:0] COND_NE = 3'd1;

  typedef struct packed {
    logic [OPK_W-1:0]   kind;
    logic [VALUE_W-1:0] val;
  } opnd_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    opnd_t             a;
    opnd_t             b;
    logic [IDX_W-1:0]  dst;
    logic [IDX_W-1:0]  label;
    logic [IDX_W-1:0]  frame;
    logic [STEP_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              is_alloc;
    opnd_t             src;
    opnd_t             dst;
    logic [COND_W-1:0] cond;
    logic [IDX_W-1:0]  label;
  } res_t;

  function automatic opnd_t mk_src(logic is_imm, logic [VALUE_W-1:0] value);
    opnd_t o;
    if (is_imm) begin
      o = {OPK_IMM, value};
    end else begin
      o = {OPK_PSEUDO, VALUE_W'(value[IDX_W-1:0])};
    end
    return o;
  endfunction

  function automatic opnd_t reg_op(logic [OPK_W-1:0] k);
    return {k, VALUE_W'(0)};
  endfunction

  function automatic res_t rec(logic [OP_W-1:0] op, logic flag, opnd_t s, opnd_t d,
                               logic [COND_W-1:0] cond, logic [IDX_W-1:0] label);
    res_t r;
    r.op       = op;
    r.is_alloc = flag;
    r.src      = s;
    r.dst      = d;
    r.cond     = cond;
    r.label    = label;
    return r;
  endfunction

  // one step of a move; pseudo to pseudo goes through R10 in two steps
  function automatic res_t mv_step(opnd_t s, opnd_t d, logic second);
    res_t r;
    if (s.kind == OPK_PSEUDO && d.kind == OPK_PSEUDO) begin
      r = second ? rec(OP_MOV, 1'b0, reg_op(OPK_R10), d, COND_E, '0)
                 : rec(OP_MOV, 1'b0, s, reg_op(OPK_R10), COND_E, '0);
    end else begin
      r = rec(OP_MOV, 1'b0, s, d, COND_E, '0);
    end
    return r;
  endfunction

  // number of instructions an item cracks into; zero for an unknown kind
  function automatic logic [STEP_W-1:0] expand_count(logic [KIND_W-1:0] kind,
                                                     logic a_p, logic b_p);
    logic [STEP_W-1:0] ma;
    logic [STEP_W-1:0] n;
    ma = a_p ? 3'd2 : 3'd1;
    case (kind)
      KIND_START, KIND_JMP, KIND_LABEL:                n = 3'd1;
      KIND_RETURN:                                     n = 3'd2;
      KIND_NEG, KIND_NOT:                              n = 3'(ma + 3'd1);
      KIND_LNOT:                                       n = a_p ? 3'd3 : 3'd4;
      KIND_ADD, KIND_SUB, KIND_AND, KIND_OR, KIND_XOR:
        n = 3'(ma + (b_p ? 3'd2 : 3'd1));
      KIND_MUL:                                        n = 3'd4;
      KIND_SHL, KIND_SHR:                              n = 3'(ma + 3'd2);
      KIND_DIV, KIND_REM:                              n = b_p ? 3'd4 : 3'd5;
      KIND_JZ, KIND_JNZ:                               n = a_p ? 3'd2 : 3'd3;
      KIND_EQ, KIND_NE, KIND_GT, KIND_LT, KIND_GE, KIND_LE:
        n = (a_p == b_p) ? 3'd4 : 3'd3;
      KIND_COPY:                                       n = ma;
      default:                                         n = 3'd0;
    endcase
    return n;
  endfunction

  // instruction number idx of the expansion of one item
  function automatic res_t expand_step(item_t it, logic [STEP_W-1:0] idx);
    res_t              r;
    opnd_t             dv;
    opnd_t             imm0;
    opnd_t             s;
    opnd_t             d;
    logic              a_p;
    logic              b_p;
    logic [STEP_W-1:0] ma;
    logic [STEP_W-1:0] cz;
    logic [STEP_W-1:0] co;
    logic [KIND_W-1:0] rel;
    logic [OP_W-1:0]   aop;
    dv   = {OPK_PSEUDO, VALUE_W'(it.dst)};
    imm0 = reg_op(OPK_IMM);
    a_p  = (it.a.kind == OPK_PSEUDO);
    b_p  = (it.b.kind == OPK_PSEUDO);
    ma   = a_p ? 3'd2 : 3'd1;
    cz   = a_p ? 3'd1 : 3'd2;
    co   = (a_p == b_p) ? 3'd2 : 3'd1;
    rel  = it.kind - KIND_EQ;
    s    = (a_p && b_p) ? reg_op(OPK_R10) : it.a;
    d    = (!a_p && !b_p) ? reg_op(OPK_R10) : it.b;
    case (it.kind)
      KIND_ADD: aop = OP_ADD;
      KIND_SUB: aop = OP_SUB;
      KIND_AND: aop = OP_AND;
      KIND_OR:  aop = OP_OR;
      KIND_SHL: aop = OP_SHL;
      KIND_SHR: aop = OP_SAR;
      KIND_NEG: aop = OP_NEG;
      KIND_NOT: aop = OP_NOT;
      default:  aop = OP_XOR;
    endcase
    r = '0;
    case (it.kind)
      KIND_START: begin
        r = rec(OP_RET, 1'b1, {OPK_IMM, VALUE_W'(it.frame)}, imm0, COND_E, '0);
      end
      KIND_RETURN: begin
        r = (idx == 3'd0) ? rec(OP_MOV, 1'b0, it.a, reg_op(OPK_AX), COND_E, '0)
                          : rec(OP_RET, 1'b0, imm0, imm0, COND_E, '0);
      end
      KIND_NEG, KIND_NOT: begin
        r = (idx < ma) ? mv_step(it.a, dv, idx[0])
                       : rec(aop, 1'b0, imm0, dv, COND_E, '0);
      end
      KIND_LNOT, KIND_JZ, KIND_JNZ: begin
        // compare against zero; an immediate goes to R10 first
        if (!a_p && idx == 3'd0) begin
          r = rec(OP_MOV, 1'b0, it.a, reg_op(OPK_R10), COND_E, '0);
        end else if (idx == 3'(cz - 3'd1)) begin
          r = rec(OP_CMP, 1'b0, imm0, a_p ? it.a : reg_op(OPK_R10), COND_E, '0);
        end else if (it.kind == KIND_JZ) begin
          r = rec(OP_JMP, 1'b1, imm0, imm0, COND_E, it.label);
        end else if (it.kind == KIND_JNZ) begin
          r = rec(OP_JMP, 1'b1, imm0, imm0, COND_NE, it.label);
        end else if (idx == cz) begin
          r = rec(OP_MOV, 1'b0, imm0, dv, COND_E, '0);
        end else begin
          r = rec(OP_SETCC, 1'b0, imm0, dv, COND_E, '0);
        end
      end
      KIND_ADD, KIND_SUB, KIND_AND, KIND_OR, KIND_XOR: begin
        if (idx < ma) begin
          r = mv_step(it.a, dv, idx[0]);
        end else if (b_p && idx == ma) begin
          r = rec(OP_MOV, 1'b0, it.b, reg_op(OPK_R10), COND_E, '0);
        end else begin
          r = rec(aop, 1'b0, b_p ? reg_op(OPK_R10) : it.b, dv, COND_E, '0);
        end
      end
      KIND_MUL: begin
        case (idx)
          3'd0:    r = rec(OP_MOV, 1'b0, it.a, reg_op(OPK_R10), COND_E, '0);
          3'd1:    r = rec(OP_MOV, 1'b0, it.b, reg_op(OPK_R11), COND_E, '0);
          3'd2:    r = rec(OP_IMUL, 1'b0, reg_op(OPK_R10), reg_op(OPK_R11), COND_E, '0);
          default: r = rec(OP_MOV, 1'b0, reg_op(OPK_R11), dv, COND_E, '0);
        endcase
      end
      KIND_SHL, KIND_SHR: begin
        if (idx < ma) begin
          r = mv_step(it.a, dv, idx[0]);
        end else if (idx == ma) begin
          r = rec(OP_MOV, 1'b0, it.b, reg_op(OPK_CX), COND_E, '0);
        end else begin
          r = rec(aop, 1'b0, reg_op(OPK_CX), dv, COND_E, '0);
        end
      end
      KIND_DIV, KIND_REM: begin
        if (idx == 3'd0) begin
          r = rec(OP_MOV, 1'b0, it.a, reg_op(OPK_AX), COND_E, '0);
        end else if (idx == 3'd1) begin
          r = rec(OP_CDQ, 1'b0, imm0, imm0, COND_E, '0);
        end else if (!b_p && idx == 3'd2) begin
          r = rec(OP_MOV, 1'b0, it.b, reg_op(OPK_R10), COND_E, '0);
        end else if (idx == (b_p ? 3'd2 : 3'd3)) begin
          r = rec(OP_IDIV, 1'b0, imm0, b_p ? it.b : reg_op(OPK_R10), COND_E, '0);
        end else begin
          r = rec(OP_MOV, 1'b0, reg_op((it.kind == KIND_REM) ? OPK_DX : OPK_AX), dv,
                  COND_E, '0);
        end
      end
      KIND_JMP: begin
        r = rec(OP_JMP, 1'b0, imm0, imm0, COND_E, it.label);
      end
      KIND_EQ, KIND_NE, KIND_GT, KIND_LT, KIND_GE, KIND_LE: begin
        if (co == 3'd2 && idx == 3'd0) begin
          r = rec(OP_MOV, 1'b0, a_p ? it.a : it.b, reg_op(OPK_R10), COND_E, '0);
        end else if (idx == 3'(co - 3'd1)) begin
          r = rec(OP_CMP, 1'b0, s, d, COND_E, '0);
        end else if (idx == co) begin
          r = rec(OP_MOV, 1'b0, imm0, dv, COND_E, '0);
        end else begin
          r = rec(OP_SETCC, 1'b0, imm0, dv, rel[COND_W-1:0], '0);
        end
      end
      KIND_COPY: begin
        r = mv_step(it.a, dv, idx[0]);
      end
      KIND_LABEL: begin
        r = rec(OP_LABEL, 1'b0, imm0, imm0, COND_E, it.label);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/taxe_front.sv -----
// Front end: input register that classifies each item and sizes its expansion.
`timescale 1ns / 1ps

module taxe_front import taxe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic                      first_is_imm_i,
  input  logic signed [VALUE_W-1:0] first_value_i,
  input  logic                      second_is_imm_i,
  input  logic signed [VALUE_W-1:0] second_value_i,
  input  logic [IDX_W-1:0]          dest_var_i,
  input  logic [IDX_W-1:0]          label_id_i,
  input  logic [IDX_W-1:0]          frame_slots_i,
  output logic                      push_o,
  output item_t                     push_item_o,
  input  logic                      full_i
);

  logic  hold_valid_q;
  logic  hold_valid_d;
  item_t hold_item_q;
  item_t item_d;

  always_comb begin
    item_d.kind  = kind_i;
    item_d.a     = mk_src(first_is_imm_i, first_value_i);
    item_d.b     = mk_src(second_is_imm_i, second_value_i);
    item_d.dst   = dest_var_i;
    item_d.label = label_id_i;
    item_d.frame = frame_slots_i;
    item_d.count = expand_count(kind_i, !first_is_imm_i, !second_is_imm_i);
  end

  // unknown kinds expand to nothing and are dropped here
  assign hold_valid_d = in_valid_i && (item_d.count != '0);

  assign in_stall_o  = hold_valid_q && full_i;
  assign push_o      = hold_valid_q && !full_i;
  assign push_item_o = hold_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && hold_valid_d) begin
      hold_item_q <= item_d;
    end
  end

endmodule

// ----- hdl/taxe_queue.sv -----
// Short FIFO of classified items between front and back ends.
`timescale 1ns / 1ps

module taxe_queue import taxe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [QCNT_W-1:0] cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/taxe_back.sv -----
// Back end: steps through the expansion of the head item, one instruction per cycle while the output is not stalled.
`timescale 1ns / 1ps

module taxe_back import taxe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  item_t                     head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OP_W-1:0]           op_o,
  output logic                      is_alloc_o,
  output logic [OPK_W-1:0]          src_kind_o,
  output logic signed [VALUE_W-1:0] src_value_o,
  output logic [OPK_W-1:0]          dst_kind_o,
  output logic signed [VALUE_W-1:0] dst_value_o,
  output logic [COND_W-1:0]         cond_o,
  output logic [IDX_W-1:0]          label_out_o,
  output logic                      last_o
);

  logic              out_valid_q;
  res_t              res_q;
  res_t              res_d;
  logic              last_q;
  logic [STEP_W-1:0] step_q;
  logic              load;
  logic              issue;
  logic              is_last;

  assign load    = !out_valid_q || !out_stall_i;
  assign issue   = load && !empty_i;
  assign res_d   = expand_step(head_i, step_q);
  assign is_last = (step_q == STEP_W'(head_i.count - 3'd1));
  assign pop_o   = issue && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (issue) begin
        step_q <= is_last ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      res_q  <= res_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign op_o        = res_q.op;
  assign is_alloc_o  = res_q.is_alloc;
  assign src_kind_o  = res_q.src.kind;
  assign src_value_o = $signed(res_q.src.val);
  assign dst_kind_o  = res_q.dst.kind;
  assign dst_value_o = $signed(res_q.dst.val);
  assign cond_o      = res_q.cond;
  assign label_out_o = res_q.label;
  assign last_o      = last_q;

endmodule

// ----- hdl/three_address_to_x86_expander_unit.sv -----
// Top level of the three-address to x86 instruction expander.
`timescale 1ns / 1ps

// Takes one three-address instruction per transfer on the input channel and
// emits its one to five x86-style instructions, in order, one per transfer on
// the output channel; last_o marks the final instruction of each expansion and
// unknown kinds (above label) emit nothing. The output port produces one
// instruction per cycle while out_stall_i is low, so an item occupies the back
// end for as many output transfers as instructions it expands into: 1 for
// start, jmp, label and copy of an immediate, up to 5 for divide by an
// immediate. Instructions of successive items follow each other with no gap.
// The front end is a single input register that classifies the item and
// counts its expansion; a four-entry queue sits between it and the back end,
// so input transfers keep being taken while the back end works through a long
// expansion or the output is stalled. An item reaches the output through the
// input register, the queue and the output register. in_stall_o rises only
// when the input register holds an item and the queue is full.
module three_address_to_x86_expander_unit import taxe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic                      first_is_imm_i,
  input  logic signed [VALUE_W-1:0] first_value_i,
  input  logic                      second_is_imm_i,
  input  logic signed [VALUE_W-1:0] second_value_i,
  input  logic [IDX_W-1:0]          dest_var_i,
  input  logic [IDX_W-1:0]          label_id_i,
  input  logic [IDX_W-1:0]          frame_slots_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OP_W-1:0]           op_o,
  output logic                      is_alloc_o,
  output logic [OPK_W-1:0]          src_kind_o,
  output logic signed [VALUE_W-1:0] src_value_o,
  output logic [OPK_W-1:0]          dst_kind_o,
  output logic signed [VALUE_W-1:0] dst_value_o,
  output logic [COND_W-1:0]         cond_o,
  output logic [IDX_W-1:0]          label_out_o,
  output logic                      last_o
);

  // front -> queue
  logic  push;
  item_t push_item;
  logic  full;
  // queue -> back
  logic  pop;
  logic  empty;
  item_t head;

  // classify and size each item
  taxe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .first_is_imm_i  (first_is_imm_i),
    .first_value_i   (first_value_i),
    .second_is_imm_i (second_is_imm_i),
    .second_value_i  (second_value_i),
    .dest_var_i      (dest_var_i),
    .label_id_i      (label_id_i),
    .frame_slots_i   (frame_slots_i),
    .push_o          (push),
    .push_item_o     (push_item),
    .full_i          (full)
  );

  // decouples input transfers from the output stream
  taxe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // one instruction per cycle into the output register unless the output stalls; pops on the last one
  taxe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .op_o        (op_o),
    .is_alloc_o  (is_alloc_o),
    .src_kind_o  (src_kind_o),
    .src_value_o (src_value_o),
    .dst_kind_o  (dst_kind_o),
    .dst_value_o (dst_value_o),
    .cond_o      (cond_o),
    .label_out_o (label_out_o),
    .last_o      (last_o)
  );

endmodule

// ----- dv/taxe_expansion_checker.sv -----
// Checker for the expander: predicts each instruction's cracked sequence and compares results.
`timescale 1ns / 1ps

module taxe_expansion_checker import taxe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel, observed
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic                      first_is_imm_i,
  input  logic signed [VALUE_W-1:0] first_value_i,
  input  logic                      second_is_imm_i,
  input  logic signed [VALUE_W-1:0] second_value_i,
  input  logic [IDX_W-1:0]          dest_var_i,
  input  logic [IDX_W-1:0]          label_id_i,
  input  logic [IDX_W-1:0]          frame_slots_i,
  // output channel, observed
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [OP_W-1:0]           op_i,
  input  logic                      is_alloc_i,
  input  logic [OPK_W-1:0]          src_kind_i,
  input  logic signed [VALUE_W-1:0] src_value_i,
  input  logic [OPK_W-1:0]          dst_kind_i,
  input  logic signed [VALUE_W-1:0] dst_value_i,
  input  logic [COND_W-1:0]         cond_i,
  input  logic [IDX_W-1:0]          label_out_i,
  input  logic                      last_i,
  // to the testbench top
  output int                        mismatches_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [OPK_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
  } operand_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               is_alloc;
    logic [OPK_W-1:0]   src_kind;
    logic [VALUE_W-1:0] src_value;
    logic [OPK_W-1:0]   dst_kind;
    logic [VALUE_W-1:0] dst_value;
    logic [COND_W-1:0]  cond;
    logic [IDX_W-1:0]   label;
    logic               last;
  } x86_instr_t;

  x86_instr_t expected_instrs[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  function automatic operand_t reg_operand(logic [OPK_W-1:0] k);
    return {k, {VALUE_W{1'b0}}};
  endfunction

  // pseudo indexes wrap to the 16-bit slot space
  function automatic operand_t source_operand(logic is_imm, logic [VALUE_W-1:0] value);
    if (is_imm) return {OPK_IMM, value};
    return {OPK_PSEUDO, {{(VALUE_W-IDX_W){1'b0}}, value[IDX_W-1:0]}};
  endfunction

  function automatic void emit_instr(logic [OP_W-1:0] op, logic flag, operand_t s,
                                     operand_t d, logic [COND_W-1:0] cc,
                                     logic [IDX_W-1:0] lbl);
    x86_instr_t r;
    r.op        = op;
    r.is_alloc  = flag;
    r.src_kind  = s.kind;
    r.src_value = s.value;
    r.dst_kind  = d.kind;
    r.dst_value = d.value;
    r.cond      = cc;
    r.label     = lbl;
    r.last      = 1'b0;
    expected_instrs.push_back(r);
  endfunction

  // memory to memory is illegal, so pseudo to pseudo goes through R10
  function automatic void emit_move(operand_t s, operand_t d);
    if (s.kind == OPK_PSEUDO && d.kind == OPK_PSEUDO) begin
      emit_instr(OP_MOV, 1'b0, s, reg_operand(OPK_R10), COND_E, '0);
      emit_instr(OP_MOV, 1'b0, reg_operand(OPK_R10), d, COND_E, '0);
    end else begin
      emit_instr(OP_MOV, 1'b0, s, d, COND_E, '0);
    end
  endfunction

  function automatic void emit_setcc(logic [COND_W-1:0] cc, operand_t d);
    emit_instr(OP_MOV, 1'b0, {OPK_IMM, {VALUE_W{1'b0}}}, d, COND_E, '0);
    emit_instr(OP_SETCC, 1'b0, reg_operand(OPK_IMM), d, cc, '0);
  endfunction

  function automatic void emit_cmp_zero(operand_t a);
    operand_t d;
    d = a;
    if (a.kind == OPK_IMM) begin
      emit_move(a, reg_operand(OPK_R10));
      d = reg_operand(OPK_R10);
    end
    emit_instr(OP_CMP, 1'b0, {OPK_IMM, {VALUE_W{1'b0}}}, d, COND_E, '0);
  endfunction

  function automatic void predict_expansion(logic [KIND_W-1:0] kind, logic fi,
                                            logic [VALUE_W-1:0] fv, logic si,
                                            logic [VALUE_W-1:0] sv,
                                            logic [IDX_W-1:0] dest,
                                            logic [IDX_W-1:0] lbl,
                                            logic [IDX_W-1:0] slots);
    operand_t   a;
    operand_t   b;
    operand_t   dv;
    operand_t   none;
    operand_t   s;
    operand_t   d;
    logic [OP_W-1:0] alu_op;
    int         base;
    x86_instr_t tail;
    base = expected_instrs.size();
    a    = source_operand(fi, fv);
    b    = source_operand(si, sv);
    dv   = {OPK_PSEUDO, {{(VALUE_W-IDX_W){1'b0}}, dest}};
    none = reg_operand(OPK_IMM);
    case (kind)
      KIND_ADD: alu_op = OP_ADD;
      KIND_SUB: alu_op = OP_SUB;
      KIND_AND: alu_op = OP_AND;
      KIND_OR:  alu_op = OP_OR;
      default:  alu_op = OP_XOR;
    endcase
    case (kind)
      KIND_START: begin
        emit_instr(OP_RET, 1'b1, {OPK_IMM, {{(VALUE_W-IDX_W){1'b0}}, slots}}, none,
                   COND_E, '0);
      end
      KIND_RETURN: begin
        emit_move(a, reg_operand(OPK_AX));
        emit_instr(OP_RET, 1'b0, none, none, COND_E, '0);
      end
      KIND_NEG, KIND_NOT: begin
        emit_move(a, dv);
        emit_instr((kind == KIND_NEG) ? OP_NEG : OP_NOT, 1'b0, none, dv, COND_E, '0);
      end
      KIND_LNOT: begin
        emit_cmp_zero(a);
        emit_setcc(COND_E, dv);
      end
      KIND_ADD, KIND_SUB, KIND_AND, KIND_OR, KIND_XOR: begin
        s = b;
        emit_move(a, dv);
        if (b.kind == OPK_PSEUDO) begin
          emit_move(b, reg_operand(OPK_R10));
          s = reg_operand(OPK_R10);
        end
        emit_instr(alu_op, 1'b0, s, dv, COND_E, '0);
      end
      KIND_MUL: begin
        emit_move(a, reg_operand(OPK_R10));
        emit_move(b, reg_operand(OPK_R11));
        emit_instr(OP_IMUL, 1'b0, reg_operand(OPK_R10), reg_operand(OPK_R11), COND_E, '0);
        emit_move(reg_operand(OPK_R11), dv);
      end
      KIND_SHL, KIND_SHR: begin
        emit_move(a, dv);
        emit_move(b, reg_operand(OPK_CX));
        emit_instr((kind == KIND_SHL) ? OP_SHL : OP_SAR, 1'b0, reg_operand(OPK_CX), dv,
                   COND_E, '0);
      end
      KIND_DIV, KIND_REM: begin
        d = b;
        emit_move(a, reg_operand(OPK_AX));
        emit_instr(OP_CDQ, 1'b0, none, none, COND_E, '0);
        if (b.kind == OPK_IMM) begin
          emit_move(b, reg_operand(OPK_R10));
          d = reg_operand(OPK_R10);
        end
        emit_instr(OP_IDIV, 1'b0, none, d, COND_E, '0);
        emit_move(reg_operand((kind == KIND_REM) ? OPK_DX : OPK_AX), dv);
      end
      KIND_JMP: begin
        emit_instr(OP_JMP, 1'b0, none, none, COND_E, lbl);
      end
      KIND_JZ, KIND_JNZ: begin
        emit_cmp_zero(a);
        emit_instr(OP_JMP, 1'b1, none, none, (kind == KIND_JNZ) ? COND_NE : COND_E, lbl);
      end
      KIND_EQ, KIND_NE, KIND_GT, KIND_LT, KIND_GE, KIND_LE: begin
        s = a;
        d = b;
        if (a.kind == OPK_PSEUDO && b.kind == OPK_PSEUDO) begin
          emit_move(a, reg_operand(OPK_R10));
          s = reg_operand(OPK_R10);
        end
        if (a.kind == OPK_IMM && b.kind == OPK_IMM) begin
          emit_move(b, reg_operand(OPK_R10));
          d = reg_operand(OPK_R10);
        end
        emit_instr(OP_CMP, 1'b0, s, d, COND_E, '0);
        emit_setcc(COND_W'(kind - KIND_EQ), dv);
      end
      KIND_COPY: begin
        emit_move(a, dv);
      end
      KIND_LABEL: begin
        emit_instr(OP_LABEL, 1'b0, none, none, COND_E, lbl);
      end
      default: begin
      end
    endcase
    if (expected_instrs.size() > base) begin
      tail      = expected_instrs.pop_back();
      tail.last = 1'b1;
      expected_instrs.push_back(tail);
    end
  endfunction

  function automatic int field_mismatch(string name, logic [VALUE_W-1:0] want,
                                        logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    x86_instr_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        predict_expansion(kind_i, first_is_imm_i, first_value_i, second_is_imm_i,
                          second_value_i, dest_var_i, label_id_i, frame_slots_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_instrs.size() == 0) begin
          $error("unexpected instruction: op 0x%0h src 0x%0h dst 0x%0h", op_i,
                 src_value_i, dst_value_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = expected_instrs.pop_front();
          mismatches_o = mismatches_o
            + field_mismatch("op", want.op, op_i)
            + field_mismatch("is_alloc", want.is_alloc, is_alloc_i)
            + field_mismatch("src_kind", want.src_kind, src_kind_i)
            + field_mismatch("src_value", want.src_value, src_value_i)
            + field_mismatch("dst_kind", want.dst_kind, dst_kind_i)
            + field_mismatch("dst_value", want.dst_value, dst_value_i)
            + field_mismatch("cond", want.cond, cond_i)
            + field_mismatch("label_out", want.label, label_out_i)
            + field_mismatch("last", want.last, last_i);
        end
      end
      pending_o = expected_instrs.size();
    end
  end

endmodule

// ----- dv/three_address_to_x86_expander_unit_tb.sv -----
// Testbench top for the three-address expander: reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module three_address_to_x86_expander_unit_tb;
  import taxe_pkg::*;

  // Worst case is about 400 items x 5 instructions, each stalled often on the
  // output side, plus input gaps; the watchdog leaves a wide margin.
  localparam int WATCHDOG_NS    = 400000;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ITEMS_PER_PASS = 110;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [KIND_W-1:0]         kind_i = '0;
  logic                      first_is_imm_i = 1'b0;
  logic signed [VALUE_W-1:0] first_value_i = '0;
  logic                      second_is_imm_i = 1'b0;
  logic signed [VALUE_W-1:0] second_value_i = '0;
  logic [IDX_W-1:0]          dest_var_i = '0;
  logic [IDX_W-1:0]          label_id_i = '0;
  logic [IDX_W-1:0]          frame_slots_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [OP_W-1:0]           op_o;
  logic                      is_alloc_o;
  logic [OPK_W-1:0]          src_kind_o;
  logic signed [VALUE_W-1:0] src_value_o;
  logic [OPK_W-1:0]          dst_kind_o;
  logic signed [VALUE_W-1:0] dst_value_o;
  logic [COND_W-1:0]         cond_o;
  logic [IDX_W-1:0]          label_out_o;
  logic                      last_o;

  int mismatches;
  int pending;

  // idle percentages per side, changed between passes
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always #1 clk_i = ~clk_i;

  three_address_to_x86_expander_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .first_is_imm_i (first_is_imm_i),
    .first_value_i  (first_value_i),
    .second_is_imm_i(second_is_imm_i),
    .second_value_i (second_value_i),
    .dest_var_i     (dest_var_i),
    .label_id_i     (label_id_i),
    .frame_slots_i  (frame_slots_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .op_o           (op_o),
    .is_alloc_o     (is_alloc_o),
    .src_kind_o     (src_kind_o),
    .src_value_o    (src_value_o),
    .dst_kind_o     (dst_kind_o),
    .dst_value_o    (dst_value_o),
    .cond_o         (cond_o),
    .label_out_o    (label_out_o),
    .last_o         (last_o)
  );

  // watches both channels and does all the prediction and comparison
  taxe_expansion_checker expansion_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .first_is_imm_i (first_is_imm_i),
    .first_value_i  (first_value_i),
    .second_is_imm_i(second_is_imm_i),
    .second_value_i (second_value_i),
    .dest_var_i     (dest_var_i),
    .label_id_i     (label_id_i),
    .frame_slots_i  (frame_slots_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .op_i           (op_o),
    .is_alloc_i     (is_alloc_o),
    .src_kind_i     (src_kind_o),
    .src_value_i    (src_value_o),
    .dst_kind_i     (dst_kind_o),
    .dst_value_i    (dst_value_o),
    .cond_i         (cond_o),
    .label_out_i    (label_out_o),
    .last_i         (last_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Output back-pressure: a fresh coin each falling edge, so stalls land on
  // every step of a multi-instruction expansion.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  // Immediates and pseudo indexes: mostly the sign/overflow corners, small
  // numbers and full-width random words (which also exercise index wrap).
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(15));
      3:       return -32'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  // One transfer on the input channel. Entered and left at a falling edge;
  // valid is left high after the transfer so that back-to-back items never
  // drop it. Gaps before the item are drawn from send_idle_pct.
  task automatic send_instr(input logic [KIND_W-1:0] k, input logic fi,
                            input logic [VALUE_W-1:0] fv, input logic si,
                            input logic [VALUE_W-1:0] sv,
                            input logic [IDX_W-1:0] dv, input logic [IDX_W-1:0] lv,
                            input logic [IDX_W-1:0] fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i          = k;
    first_is_imm_i  = fi;
    first_value_i   = fv;
    second_is_imm_i = si;
    second_value_i  = sv;
    dest_var_i      = dv;
    label_id_i      = lv;
    frame_slots_i   = fs;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted instruction has come out.
  task automatic drain_all();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random items: mostly legal kinds with random operand forms, a few unknown
  // kinds as noise (these expand to nothing and are not counted).
  task automatic send_random(input int count);
    int               sent;
    logic [KIND_W-1:0] k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 4) begin
        k = KIND_W'($urandom_range(KIND_LABEL + 1, 31));
      end else begin
        k = KIND_W'($urandom_range(KIND_LABEL));
        sent++;
      end
      send_instr(k, 1'($urandom), pick_value(), 1'($urandom), pick_value(),
                 IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first pass: sender idles a quarter of the time, receiver about half
    send_idle_pct = 25;
    recv_idle_pct = 52;

    // Directed sweep over every kind. Operand forms follow the low kind bits,
    // so compares see both-pseudo and both-immediate pairs, divide sees both
    // an immediate and a pseudo divisor, and jz/jnz see both forms.
    // First values sit at the signed extremes; indexes and labels at 0 and all-ones.
    for (int k = 0; k <= KIND_LABEL; k++) begin
      send_instr(KIND_W'(k), k[0], k[2] ? 32'h8000_0000 : 32'h7FFF_FFFF, k[1],
                 k[3] ? 32'hFFFF_FFFF : 32'h0001_0000,
                 k[0] ? 16'hFFFF : 16'h0000, k[1] ? 16'hFFFF : 16'h0000,
                 k[0] ? 16'hFFFF : 16'h0000);
    end
    // unknown kinds: nothing must come out
    send_instr(KIND_W'(KIND_LABEL + 1), 1'b1, 32'h1, 1'b1, 32'h2, 16'h1, 16'h2, 16'h3);
    send_instr(5'd31, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
               16'hFFFF);

    send_random(ITEMS_PER_PASS);
    // hold the sender until the block has fully drained once
    drain_all();

    // second pass: roles swapped
    send_idle_pct = 52;
    recv_idle_pct = 25;
    send_random(ITEMS_PER_PASS);
    drain_all();

    // last pass: full throughput on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(ITEMS_PER_PASS);
    drain_all();

    // give any stray extra instruction time to show up
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
